// ----- hw/rtl/tdh_pkg.sv -----
// Package: register indexes, field widths and threshold constants for the tilt d-pad.
`default_nettype none

package tdh_pkg;

   localparam int SampleWidth = 16;
   localparam int PctWidth    = 7;
   localparam int CsrIdxWidth = 3;
   localparam int SpanWidth   = SampleWidth - 1;          // span never exceeds 32767
   localparam int ProdWidth   = SpanWidth + PctWidth;     // span * percent
   localparam int ThrWidth    = 16;                       // threshold up to 41614
   localparam int OffWidth    = SampleWidth + 1;          // sample - centre

   // floor(x / 100) == (x * RecipMul) >> RecipShift for every x below 2**ProdWidth
   localparam int RecipShift = 29;
   localparam int RecipWidth = 23;
   localparam logic [RecipWidth-1:0] RecipMul = RecipWidth'((64'd1 << RecipShift) / 100 + 1);
   localparam int RecipProdWidth = ProdWidth + RecipWidth;

   // cycles from a register write until the thresholds are current again
   localparam logic [1:0] SettleCycles = 2'd2;

   localparam logic signed [SampleWidth-1:0] RangeMinReset   = -16'sd32768;
   localparam logic signed [SampleWidth-1:0] RangeMaxReset   = 16'sd32767;
   localparam logic [PctWidth-1:0]           PressPctReset   = 7'd30;
   localparam logic [PctWidth-1:0]           ReleasePctReset = 7'd20;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RANGE_MIN   = 3'd0,
      CSR_RANGE_MAX   = 3'd1,
      CSR_PRESS_PCT   = 3'd2,
      CSR_RELEASE_PCT = 3'd3,
      CSR_CENTRE_X    = 3'd4,
      CSR_CENTRE_Y    = 3'd5,
      CSR_CENTRE_Z    = 3'd6
   } csr_index_type;

   // held/result bit order
   typedef struct packed {
      logic down;
      logic up;
      logic right;
      logic left;
   } dirs_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tilt_dpad_hysteresis.sv -----
// Top level: accelerometer tilt to d-pad direction bits with press/release hysteresis.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   request  | req_valid/ready, req_accel_x/y/z    | in
//   response | rsp_valid/ready, rsp_dir_*          | out
//   csr      | csr_valid/ready, csr_index/wdata   | in
//
// One sample per cycle while rsp_ready is high and no csr write or settle is pending.
// A sample waits in the input register until its result loads the output register.
// The held-direction state updates as each result is loaded, so samples may follow
// each other in consecutive cycles. Thresholds come from a two-stage multiply
// pipeline fed by the csr registers; after reset and after each csr transfer the
// request side stays not-ready until the settle counter runs out and they are current.
// csr transfers are taken only when no sample is in flight. Reset is synchronous.
`default_nettype none

module tilt_dpad_hysteresis (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [tdh_pkg::SampleWidth-1:0] req_accel_x,
   input  wire logic signed [tdh_pkg::SampleWidth-1:0] req_accel_y,
   input  wire logic signed [tdh_pkg::SampleWidth-1:0] req_accel_z,

   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_dir_left,
   output logic rsp_dir_right,
   output logic rsp_dir_up,
   output logic rsp_dir_down,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tdh_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [tdh_pkg::SampleWidth-1:0]     csr_wdata
);

   // ---------------------------------------------------------------- csr regs
   logic signed [tdh_pkg::SampleWidth-1:0] range_min_ff, range_max_ff;
   logic signed [tdh_pkg::SampleWidth-1:0] centre_x_ff, centre_y_ff, centre_z_ff;
   logic [tdh_pkg::PctWidth-1:0]           press_pct_ff, release_pct_ff;
   logic [1:0]                             settle_ff, settle_in;
   logic                                   csr_xfer;

   assign csr_xfer = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff   <= tdh_pkg::RangeMinReset;
         range_max_ff   <= tdh_pkg::RangeMaxReset;
         press_pct_ff   <= tdh_pkg::PressPctReset;
         release_pct_ff <= tdh_pkg::ReleasePctReset;
         centre_x_ff    <= '0;
         centre_y_ff    <= '0;
         centre_z_ff    <= '0;
      end else if (csr_xfer) begin
         unique case (tdh_pkg::csr_index_type'(csr_index))
            tdh_pkg::CSR_RANGE_MIN:   range_min_ff   <= csr_wdata;
            tdh_pkg::CSR_RANGE_MAX:   range_max_ff   <= csr_wdata;
            tdh_pkg::CSR_PRESS_PCT:   press_pct_ff   <= csr_wdata[tdh_pkg::PctWidth-1:0];
            tdh_pkg::CSR_RELEASE_PCT: release_pct_ff <= csr_wdata[tdh_pkg::PctWidth-1:0];
            tdh_pkg::CSR_CENTRE_X:    centre_x_ff    <= csr_wdata;
            tdh_pkg::CSR_CENTRE_Y:    centre_y_ff    <= csr_wdata;
            tdh_pkg::CSR_CENTRE_Z:    centre_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // settle counter: any csr transfer (or reset) restarts the wait for the threshold pipe
   always_comb begin
      settle_in = settle_ff;
      if (csr_xfer) begin
         settle_in = tdh_pkg::SettleCycles;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= tdh_pkg::SettleCycles;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // ---------------------------------------------------------------- thresholds
   // stage 1: span and span*percent; stage 2: divide by 100 via reciprocal
   logic signed [tdh_pkg::SampleWidth:0] range_diff;
   logic [tdh_pkg::SpanWidth-1:0]        span;
   logic [tdh_pkg::PctWidth-1:0]         rel_pct;
   logic [tdh_pkg::ProdWidth-1:0]        press_prod_ff, rel_prod_ff;
   logic                                 span_pos_ff, span_ok_ff;
   logic [tdh_pkg::RecipProdWidth-1:0]   press_q, rel_q;
   logic [tdh_pkg::ThrWidth-1:0]         press_thr_ff, rel_thr_ff;

   assign range_diff = {range_max_ff[tdh_pkg::SampleWidth-1], range_max_ff}
                     - {range_min_ff[tdh_pkg::SampleWidth-1], range_min_ff};
   // only used when the difference is positive, so halving is a shift
   assign span = range_diff[tdh_pkg::SpanWidth:1];

   always_comb begin
      rel_pct = release_pct_ff;
      if (release_pct_ff >= press_pct_ff) begin
         rel_pct = (press_pct_ff > 7'd1) ? press_pct_ff - 7'd1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      press_prod_ff <= tdh_pkg::ProdWidth'(span) * tdh_pkg::ProdWidth'(press_pct_ff);
      rel_prod_ff   <= tdh_pkg::ProdWidth'(span) * tdh_pkg::ProdWidth'(rel_pct);
      span_pos_ff   <= (range_diff > 17'sd1);
   end

   assign press_q = tdh_pkg::RecipProdWidth'(press_prod_ff)
                  * tdh_pkg::RecipProdWidth'(tdh_pkg::RecipMul);
   assign rel_q   = tdh_pkg::RecipProdWidth'(rel_prod_ff)
                  * tdh_pkg::RecipProdWidth'(tdh_pkg::RecipMul);

   always_ff @(posedge clock) begin
      press_thr_ff <= press_q[tdh_pkg::RecipShift +: tdh_pkg::ThrWidth];
      rel_thr_ff   <= rel_q[tdh_pkg::RecipShift +: tdh_pkg::ThrWidth];
      span_ok_ff   <= span_pos_ff;
   end

   // ---------------------------------------------------------------- datapath
   logic                                   in_valid_ff;
   logic signed [tdh_pkg::SampleWidth-1:0] x_ff, y_ff, z_ff;
   logic                                   rsp_valid_ff;
   tdh_pkg::dirs_type                      held_ff, result;
   logic                                   advance, move, req_xfer;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign move      = in_valid_ff & advance;
   assign req_ready = (~in_valid_ff | advance) & (settle_ff == 2'd0) & ~csr_valid;
   assign req_xfer  = req_valid & req_ready;
   assign csr_ready = ~in_valid_ff & ~rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff <= req_accel_x;
         y_ff <= req_accel_y;
         z_ff <= req_accel_z;
      end
   end

   // magnitude of a centre value, 17 bits so -32768 fits
   function automatic logic [tdh_pkg::SampleWidth:0] mag(
      input logic signed [tdh_pkg::SampleWidth-1:0] v
   );
      logic signed [tdh_pkg::SampleWidth:0] w;
      w = {v[tdh_pkg::SampleWidth-1], v};
      return v[tdh_pkg::SampleWidth-1] ? tdh_pkg::OffWidth'(-w) : tdh_pkg::OffWidth'(w);
   endfunction

   function automatic logic signed [tdh_pkg::SampleWidth:0] offset(
      input logic signed [tdh_pkg::SampleWidth-1:0] s,
      input logic signed [tdh_pkg::SampleWidth-1:0] c
   );
      return {s[tdh_pkg::SampleWidth-1], s} - {c[tdh_pkg::SampleWidth-1], c};
   endfunction

   // returns {pos, neg}
   function automatic logic [1:0] judge(
      input logic signed [tdh_pkg::SampleWidth:0] off,
      input logic [tdh_pkg::ThrWidth-1:0]         on_t,
      input logic [tdh_pkg::ThrWidth-1:0]         off_t,
      input logic                                 held_neg,
      input logic                                 held_pos
   );
      logic signed [tdh_pkg::SampleWidth+1:0] o, pon, poff;
      logic [1:0] r;
      o    = {off[tdh_pkg::SampleWidth], off};
      pon  = {2'b00, on_t};
      poff = {2'b00, off_t};
      priority if (o <= -pon)               r = 2'b01;
      else if (o >= pon)                    r = 2'b10;
      else if (held_neg && (o <= -poff))    r = 2'b01;
      else if (held_pos && (o >= poff))     r = 2'b10;
      else                                  r = 2'b00;
      return r;
   endfunction

   logic [tdh_pkg::SampleWidth:0]        ax, ay, az;
   logic signed [tdh_pkg::SampleWidth:0] roll_off, pitch_off;
   logic [1:0]                           roll_dir, pitch_dir;

   always_comb begin
      ax = mag(centre_x_ff);
      ay = mag(centre_y_ff);
      az = mag(centre_z_ff);
      // posture: ties favor Y, then Z
      priority if (ay >= ax && ay >= az) begin
         roll_off  = offset(x_ff, centre_x_ff);
         pitch_off = offset(z_ff, centre_z_ff);
      end else if (az >= ax && az >= ay) begin
         roll_off  = offset(x_ff, centre_x_ff);
         pitch_off = offset(y_ff, centre_y_ff);
      end else begin
         roll_off  = offset(y_ff, centre_y_ff);
         pitch_off = offset(z_ff, centre_z_ff);
      end
      roll_dir  = judge(roll_off, press_thr_ff, rel_thr_ff, held_ff.right, held_ff.left);
      pitch_dir = judge(pitch_off, press_thr_ff, rel_thr_ff, held_ff.down, held_ff.up);
      // roll negative = right, pitch negative = down
      result.left  = span_ok_ff & roll_dir[1];
      result.right = span_ok_ff & roll_dir[0];
      result.up    = span_ok_ff & pitch_dir[1];
      result.down  = span_ok_ff & pitch_dir[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
            held_ff      <= result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // held state doubles as the output register
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dir_left  = held_ff.left;
   assign rsp_dir_right = held_ff.right;
   assign rsp_dir_up    = held_ff.up;
   assign rsp_dir_down  = held_ff.down;

`ifndef SYNTHESIS
   a_roll_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(held_ff.left && held_ff.right))
      else $error("left and right held together");

   a_pitch_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(held_ff.up && held_ff.down))
      else $error("up and down held together");

   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> !req_ready ##1 !req_ready)
      else $error("request taken before thresholds settled");

   a_empty_range: assert property (@(posedge clock) disable iff (reset)
      (move && !span_ok_ff) |=> (held_ff == '0))
      else $error("direction set with empty range");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |-> (!in_valid_ff && !rsp_valid_ff))
      else $error("csr transfer while sample in flight");
`endif

endmodule

`default_nettype wire
